### src/todq_pkg.sv
// ============================================================================
// Timestamp-ordered delay queue package
// Shared sizes, operation and status codes, and cell types.
// ============================================================================
`default_nettype none

package todq_pkg;

    localparam int DEPTH  = 16;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int TAG_W  = 8;
    localparam int DUE_W  = 32;
    localparam int DLY_W  = 20;
    localparam int WAKE_W = 21;
    localparam int KIND_W = 3;
    localparam int STAT_W = 2;

    localparam logic [WAKE_W-1:0] WAKE_MAX = WAKE_W'(1048577);

    localparam logic [KIND_W-1:0] KIND_TICK       = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_DELAY = 3'd1;
    localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd3;
    localparam logic [KIND_W-1:0] KIND_POP        = 3'd4;
    localparam logic [KIND_W-1:0] KIND_CANCEL     = 3'd5;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;
    localparam logic [STAT_W-1:0] STAT_MISS  = 2'd3;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [DUE_W-1:0] due;
    } entry_t;

    typedef struct packed {
        logic load;
        logic take_left;
        logic take_right;
    } cell_ctl_t;

    typedef struct packed {
        logic due_ge;
        logic tag_eq;
    } cell_flag_t;

endpackage

`default_nettype wire

### src/todq_cell.sv
// ============================================================================
// Queue cell
// Holds one entry, compares it with the broadcast key and shifts it toward
// or away from the head under control of the queue logic.
// ============================================================================
`default_nettype none

module todq_cell
    import todq_pkg::*;
(
    input  wire logic       clk,
    input  wire cell_ctl_t  ctl,
    input  wire entry_t     new_entry,
    input  wire entry_t     left_entry,
    input  wire entry_t     right_entry,
    output entry_t          entry,
    output cell_flag_t      flag
);

    entry_t entry_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            entry_reg <= new_entry;
        end
        else if (ctl.take_left)
        begin
            entry_reg <= left_entry;
        end
        else if (ctl.take_right)
        begin
            entry_reg <= right_entry;
        end
    end

    assign entry       = entry_reg;
    assign flag.due_ge = (entry_reg.due >= new_entry.due);
    assign flag.tag_eq = (entry_reg.tag == new_entry.tag);

endmodule

`default_nettype wire

### src/timestamp_ordered_delay_queue_unit.sv
// ============================================================================
// Timestamp-ordered delay queue
// A row of cells keeps the entries in list order; inserts, removals and
// tag matches act in parallel across the whole row.
// ============================================================================
//
//  Channel  Direction  Contents
//  s_*      in         tuser: kind[2:0]; tdata: tag, delay, stamp
//  m_*      out        tdata: pop_valid, pop_tag, status, count, head_due,
//                      head_tag, wake_valid, wake_delay
//  cfg_*    in         wake_enable write
//
// One word is taken per cycle while s_tready is high. The cell row and the
// s1 registers update at the accepting edge; the result is formed from the
// updated head while the word sits in the s1 stage and is loaded into the
// output register when that stage moves, so it passes s1, then the output register.
// Reset clears the count, the cycle counter and the wake enable; cell
// contents are not cleared. A stalled output holds the result stage, and
// s_tready drops only while both result registers are occupied and m_tready
// is low.
//
`default_nettype none

module timestamp_ordered_delay_queue_unit
    import todq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // tag[7:0], delay[27:8], stamp[59:28]
    input  wire logic [2:0]  s_tuser,   // kind[2:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // pop_valid[0], pop_tag[8:1], status[10:9],
                                        // count[15:11], head_due[16], head_tag[24:17],
                                        // wake_valid[25], wake_delay[46:26]
    input  wire logic        cfg_we,
    input  wire logic        cfg_wdata
);

    logic [CNT_W-1:0] count_reg, count_next;
    logic [DUE_W-1:0] now_reg, now_next;
    logic             wake_en_reg;

    logic              s1_valid_reg;
    logic              s1_pop_valid_reg;
    logic [TAG_W-1:0]  s1_pop_tag_reg;
    logic [STAT_W-1:0] s1_status_reg;
    logic              s1_trig_reg;

    logic              out_valid_reg;
    logic [47:0]       out_data_reg;

    logic              s_fire, s1_move;
    logic [KIND_W-1:0] kind;
    logic [TAG_W-1:0]  in_tag;
    logic [DLY_W-1:0]  in_delay;
    logic [DUE_W-1:0]  in_stamp;
    logic [DUE_W-1:0]  due_delayed, due_back;
    entry_t            new_entry;

    logic is_push, full, empty, hit, do_ins, do_rm, trig;
    logic [STAT_W-1:0] status;

    logic [DEPTH-1:0] occ, stop_vec, match_vec, ins_pref, rm_pref;
    entry_t           cell_entry [DEPTH];
    cell_flag_t       cell_flag  [DEPTH];
    cell_ctl_t        cell_ctl   [DEPTH];

    // ------------------------------------------------------------------
    // Input decode
    // ------------------------------------------------------------------
    assign s_fire   = s_tvalid && s_tready;
    assign kind     = s_tuser;
    assign in_tag   = s_tdata[7:0];
    assign in_delay = s_tdata[27:8];
    assign in_stamp = s_tdata[59:28];

    assign due_delayed = now_reg + DUE_W'(in_delay);
    assign due_back    = due_delayed + DUE_W'(1);

    always_comb
    begin
        new_entry.tag = in_tag;
        if (kind == KIND_PUSH_FRONT)
        begin
            new_entry.due = in_stamp;
        end
        else if (kind == KIND_PUSH_BACK)
        begin
            new_entry.due = due_back;
        end
        else
        begin
            new_entry.due = due_delayed;
        end
    end

    assign is_push = (kind == KIND_PUSH_DELAY) || (kind == KIND_PUSH_BACK)
                  || (kind == KIND_PUSH_FRONT);
    assign full    = (count_reg >= CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign hit     = |match_vec;

    assign do_ins = s_fire && is_push && !full;
    assign do_rm  = s_fire && (((kind == KIND_POP) && !empty)
                            || ((kind == KIND_CANCEL) && hit));

    // ------------------------------------------------------------------
    // Cell row
    // ------------------------------------------------------------------
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        assign occ[i]       = (count_reg > CNT_W'(i));
        // An insert lands at the head for a front push; otherwise at the first empty slot
        // or, for a delayed push, at the first entry that is due no earlier than the new one.
        assign stop_vec[i]  = !occ[i] || (kind == KIND_PUSH_FRONT)
                           || ((kind == KIND_PUSH_DELAY) && cell_flag[i].due_ge);
        assign match_vec[i] = occ[i] && cell_flag[i].tag_eq;
        assign ins_pref[i]  = |stop_vec[i:0];
        assign rm_pref[i]   = (kind == KIND_POP) || (|match_vec[i:0]);

        if (i == 0)
        begin : g_head
            assign cell_ctl[i].load      = do_ins && ins_pref[i];
            assign cell_ctl[i].take_left = 1'b0;
        end
        else
        begin : g_body
            assign cell_ctl[i].load      = do_ins && ins_pref[i] && !ins_pref[i-1];
            assign cell_ctl[i].take_left = do_ins && ins_pref[i-1];
        end
        assign cell_ctl[i].take_right = do_rm && rm_pref[i];

        todq_cell u_cell
        (
            .clk         (clk),
            .ctl         (cell_ctl[i]),
            .new_entry   (new_entry),
            .left_entry  ((i == 0) ? new_entry : cell_entry[(i == 0) ? 0 : i - 1]),
            .right_entry (cell_entry[(i == DEPTH - 1) ? i : i + 1]),
            .entry       (cell_entry[i]),
            .flag        (cell_flag[i])
        );
    end

    // ------------------------------------------------------------------
    // Count, cycle counter and per-word flags
    // ------------------------------------------------------------------
    always_comb
    begin
        count_next = count_reg;
        if (do_ins)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_rm)
        begin
            count_next = count_reg - CNT_W'(1);
        end

        now_next = now_reg;
        if (s_fire && (kind == KIND_TICK))
        begin
            now_next = now_reg + DUE_W'(1);
        end

        status = STAT_OK;
        if (is_push && full)
        begin
            status = STAT_FULL;
        end
        else if ((kind == KIND_POP) && empty)
        begin
            status = STAT_EMPTY;
        end
        else if ((kind == KIND_CANCEL) && !hit)
        begin
            status = STAT_MISS;
        end

        // Wake after a delayed or back push into an empty queue, or a pop that leaves entries.
        trig = (do_ins && (kind != KIND_PUSH_FRONT) && empty)
            || ((kind == KIND_POP) && (count_reg > CNT_W'(1)));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            now_reg     <= '0;
            wake_en_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            now_reg   <= now_next;
            if (cfg_we)
            begin
                wake_en_reg <= cfg_wdata;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result stage: reads the state left by the word it describes.
    // ------------------------------------------------------------------
    assign s1_move  = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_move;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            s1_pop_valid_reg <= (kind == KIND_POP) && !empty;
            s1_pop_tag_reg   <= ((kind == KIND_POP) && !empty) ? cell_entry[0].tag : '0;
            s1_status_reg    <= status;
            s1_trig_reg      <= trig;
        end
    end

    logic              head_exists, due_le, wake_valid, head_due;
    logic [DUE_W-1:0]  due_diff;
    logic [WAKE_W-1:0] wake_delay;
    logic [TAG_W-1:0]  head_tag;

    always_comb
    begin
        head_exists = (count_reg != '0);
        due_le      = (cell_entry[0].due <= now_reg);
        due_diff    = cell_entry[0].due - now_reg;
        head_due    = head_exists && due_le;
        head_tag    = head_exists ? cell_entry[0].tag : '0;
        wake_valid  = head_exists && s1_trig_reg && wake_en_reg;
        wake_delay  = '0;
        if (wake_valid)
        begin
            if (due_le)
            begin
                wake_delay = WAKE_W'(1);
            end
            else if (due_diff > DUE_W'(WAKE_MAX))
            begin
                wake_delay = WAKE_MAX;
            end
            else
            begin
                wake_delay = due_diff[WAKE_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_data_reg <= {1'b0, wake_delay, wake_valid, head_tag, head_due,
                             count_reg, s1_status_reg, s1_pop_tag_reg, s1_pop_valid_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count exceeds depth");

    a_ready_block : assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !m_tready) |-> !s_tready)
        else $error("input taken while result stage is blocked");

    a_pop_count : assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && (kind == KIND_POP) && !empty) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("pop did not shorten the queue");

    a_wake_head : assert property (@(posedge clk) disable iff (!rst_n)
        (s1_move && wake_valid) |-> (head_exists && wake_en_reg && wake_delay != '0))
        else $error("wake request without a head entry");

endmodule

`default_nettype wire
